[rtl/bpfm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfm_pkg
// shared types and constants for the buffer pool frame manager
// ----------------------------------------------------------------------------
package bpfm_pkg;

  localparam int NumFrames = 16;
  localparam int FrameBits = $clog2(NumFrames);
  localparam int CountBits = $clog2(NumFrames + 1);
  localparam int PinBits   = 16;
  localparam int PageBits  = 31;
  localparam int IoBits    = 32;
  localparam logic [PinBits-1:0] PinMax = {PinBits{1'b1}};

  typedef enum logic [1:0] {
    OP_PIN   = 2'd0,
    OP_UNPIN = 2'd1,
    OP_DIRTY = 2'd2,
    OP_FORCE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_ALLPIN  = 2'd2,
    ST_PINFULL = 2'd3
  } status_t;

  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_FRAMES = 1'b1;

  typedef struct packed {
    logic [1:0]          status;
    logic [FrameBits-1:0] frame_index;
    logic                hit;
    logic                evicted_valid;
    logic [PageBits-1:0] evicted_page;
    logic                wrote_back;
    logic [IoBits-1:0]   read_io_count;
    logic [IoBits-1:0]   write_io_count;
  } result_t;

  // request from the sequencer to the shared frame scan unit
  typedef struct packed {
    logic                 start;
    logic [FrameBits-1:0] first;
  } scan_req_t;

  typedef struct packed {
    logic                 done;
    logic                 found;
    logic [FrameBits-1:0] frame;
  } scan_rsp_t;

endpackage

[rtl/buffer_pool_frame_manager_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager_unit
// page frame pool with pin/unpin/dirty/force, fifo or lru replacement
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: opcode[1:0], page_number[32:2]
// m_axis    out  tdata: status, frame_index, hit, evicted_valid, evicted_page,
//                       wrote_back, read_io_count, write_io_count
// cfg       in   wr_en, wr_index, wr_data
// frame search, empty search and victim search each walk the frames one per
// cycle in a single shared compare unit. rst is synchronous. the next item is
// taken once the result register is free; an output stall holds the block.
// ----------------------------------------------------------------------------
module buffer_pool_frame_manager_unit import bpfm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [39:0]   s_axis_tdata,   // opcode, page_number
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // status, frame_index, hit, evicted_valid,
                                        // evicted_page, wrote_back, read_io_count,
                                        // write_io_count
  input  logic          wr_en,
  input  logic          wr_index,
  input  logic [4:0]    wr_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIND  = 7'b0000010,
    S_EMPTY = 7'b0000100,
    S_VICT  = 7'b0001000,
    S_EXEC  = 7'b0010000,
    S_TOUCH = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic mode;
  logic [4:0] frames_cfg;
  logic [PageBits-1:0] frame_page [NumFrames];
  logic [NumFrames-1:0] fvalid, fdirty;
  logic [PinBits-1:0] pins [NumFrames];
  logic [FrameBits-1:0] order [NumFrames];
  logic [FrameBits-1:0] fifo_pointer;
  logic [IoBits-1:0] reads_total, writes_total;

  opcode_t op;
  logic [PageBits-1:0] page;
  logic found;
  logic [FrameBits-1:0] fidx, tgt;
  logic have_tgt, evict;
  logic [FrameBits-1:0] tpos;
  logic [CountBits-1:0] n;
  result_t res;

  scan_req_t sreq;
  scan_rsp_t srsp;
  logic [FrameBits-1:0] cur, cand_f;
  logic cand_hit;
  logic [CountBits-1:0] limit;

  always_comb begin
    if (frames_cfg == 5'd0) n = CountBits'(1);
    else if (frames_cfg > 5'(NumFrames)) n = CountBits'(NumFrames);
    else n = CountBits'(frames_cfg);
  end

  // fifo wraps within n: cur counts offset from start
  logic [FrameBits:0] fsum;
  logic [FrameBits-1:0] fstart;
  assign fstart = ({1'b0, fifo_pointer} < n) ? fifo_pointer : '0;
  assign fsum = {1'b0, fstart} + {1'b0, cur};

  always_comb begin
    cand_f = cur;
    cand_hit = 1'b0;
    limit = n;
    case (state)
      S_FIND:  cand_hit = fvalid[cur] && frame_page[cur] == page;
      S_EMPTY: cand_hit = !fvalid[cur];
      S_VICT: begin
        if (mode) begin
          cand_f = order[cur];
          limit = CountBits'(NumFrames);
          cand_hit = ({1'b0, cand_f} < n) && pins[cand_f] == '0;
        end else begin
          cand_f = (fsum >= n) ? FrameBits'(fsum - n) : FrameBits'(fsum);
          cand_hit = pins[cand_f] == '0;
        end
      end
      default: cand_hit = 1'b0;
    endcase
  end

  bpfm_scan u_scan (
    .clk(clk), .rst(rst), .req(sreq), .limit(limit),
    .cand_hit(cand_hit), .cur(cur), .rsp(srsp)
  );

  // victim frame captured at the cycle of the hit
  logic [FrameBits-1:0] vict_f;
  always_ff @(posedge clk) if (state == S_VICT && cand_hit) vict_f <= cand_f;

  assign s_axis_tready = state == S_IDLE;
  assign m_axis_tvalid = state == S_OUT;
  assign m_axis_tdata = {res.write_io_count, res.read_io_count, res.wrote_back,
    res.evicted_page, res.evicted_valid, res.hit, res.frame_index, res.status};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= 1'b0;
      frames_cfg <= 5'd16;
      fvalid <= '0;
      fdirty <= '0;
      fifo_pointer <= '0;
      reads_total <= '0;
      writes_total <= '0;
      sreq <= '0;
      for (int i = 0; i < NumFrames; i++) begin
        pins[i] <= '0;
        order[i] <= FrameBits'(i);
      end
    end else begin
      sreq.start <= 1'b0;
      if (wr_en) begin
        if (wr_index == CFG_MODE) mode <= wr_data[0];
        else frames_cfg <= wr_data;
      end
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          op <= opcode_t'(s_axis_tdata[1:0]);
          page <= s_axis_tdata[32:2];
          sreq.start <= 1'b1;
          sreq.first <= '0;
          state <= S_FIND;
        end
        S_FIND: if (srsp.done) begin
          found <= srsp.found;
          fidx <= srsp.found ? srsp.frame : '0;
          have_tgt <= 1'b0;
          evict <= 1'b0;
          if (!srsp.found && op == OP_PIN) begin
            sreq.start <= 1'b1;
            state <= S_EMPTY;
          end else state <= S_EXEC;
        end
        S_EMPTY: if (srsp.done) begin
          sreq.start <= !srsp.found;
          have_tgt <= srsp.found;
          tgt <= srsp.frame;
          state <= srsp.found ? S_EXEC : S_VICT;
        end
        S_VICT: if (srsp.done) begin
          have_tgt <= srsp.found;
          evict <= srsp.found;
          tgt <= vict_f;
          state <= S_EXEC;
        end
        S_EXEC: begin
          res <= '0;
          res.frame_index <= fidx;
          res.hit <= found;
          res.read_io_count <= reads_total;
          res.write_io_count <= writes_total;
          state <= S_OUT;
          case (op)
            OP_PIN: if (found) begin
              if (pins[fidx] == PinMax) res.status <= ST_PINFULL;
              else begin
                pins[fidx] <= pins[fidx] + 1'b1;
                tgt <= fidx;
                state <= S_TOUCH;
              end
            end else if (!have_tgt) begin
              res.status <= ST_ALLPIN;
            end else begin
              if (evict) begin
                res.evicted_valid <= 1'b1;
                res.evicted_page <= frame_page[tgt];
                if (fdirty[tgt]) begin
                  res.wrote_back <= 1'b1;
                  writes_total <= writes_total + 1'b1;
                  res.write_io_count <= writes_total + 1'b1;
                end
                if (!mode) fifo_pointer <= ({1'b0, tgt} + 1'b1 >= n) ? '0 : tgt + 1'b1;
              end
              frame_page[tgt] <= page;
              fvalid[tgt] <= 1'b1;
              fdirty[tgt] <= 1'b0;
              pins[tgt] <= PinBits'(1);
              reads_total <= reads_total + 1'b1;
              res.read_io_count <= reads_total + 1'b1;
              res.frame_index <= tgt;
              state <= S_TOUCH;
            end
            OP_UNPIN: if (found && pins[fidx] != '0) pins[fidx] <= pins[fidx] - 1'b1;
              else res.status <= ST_ABSENT;
            OP_DIRTY: if (found) fdirty[fidx] <= 1'b1;
              else res.status <= ST_ABSENT;
            default: if (found) begin
              if (fdirty[fidx]) begin
                fdirty[fidx] <= 1'b0;
                writes_total <= writes_total + 1'b1;
                res.write_io_count <= writes_total + 1'b1;
                res.wrote_back <= 1'b1;
              end
            end else res.status <= ST_ABSENT;
          endcase
        end
        S_TOUCH: begin
          // shift entries after tgt's position down, put tgt at the top
          for (int q = 0; q < NumFrames - 1; q++)
            if (FrameBits'(q) >= tpos) order[q] <= order[q + 1];
          order[NumFrames-1] <= tgt;
          state <= S_OUT;
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    tpos = '0;
    for (int p = NumFrames - 1; p >= 0; p--)
      if (order[p] == tgt) tpos = FrameBits'(p);
  end

endmodule

[rtl/bpfm_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfm_scan
// shared compare unit: steps through candidate frames one per cycle
// ----------------------------------------------------------------------------
module bpfm_scan import bpfm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  scan_req_t            req,
  input  logic [CountBits-1:0] limit,
  input  logic                 cand_hit,    // candidate at cur matches
  output logic [FrameBits-1:0] cur,
  output scan_rsp_t            rsp
);

  logic [CountBits-1:0] steps;
  logic                 busy;
  logic [FrameBits-1:0] pos;

  assign cur = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp  <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        pos   <= req.first;
        steps <= '0;
      end else if (busy) begin
        if (cand_hit) begin
          busy      <= 1'b0;
          rsp.done  <= 1'b1;
          rsp.found <= 1'b1;
          rsp.frame <= pos;
        end else if (steps + 1'b1 >= limit) begin
          busy      <= 1'b0;
          rsp.done  <= 1'b1;
          rsp.found <= 1'b0;
        end else begin
          steps <= steps + 1'b1;
          pos   <= pos + 1'b1;
        end
      end
    end
  end

endmodule

[rtl/bpfm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfm_checker
// port-level checks on the frame manager
// ----------------------------------------------------------------------------
module bpfm_checker import bpfm_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);

  // one item in flight: no input taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready with result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");

  // a pin-full status always reports a hit
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] == ST_PINFULL |-> m_axis_tdata[6])
    else $error("pin full without hit");

  // eviction never coincides with a hit
  a_ev: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[7] |-> !m_axis_tdata[6] && m_axis_tdata[1:0] == ST_OK)
    else $error("bad eviction");

endmodule

bind buffer_pool_frame_manager_unit bpfm_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
